### hw/rtl/mrb_pkg.sv
// mrb_pkg: shared constants and types for the maximal rectangle block
// no dependencies; used by mrb_stack_cell and max_rectangle_binary_matrix
package mrb_pkg;

  localparam int MAX_COLS_DEF  = 64;
  localparam int MAX_ROWS_DEF  = 64;
  localparam int AREA_W        = 13;
  localparam int AREA_MAX      = 8191;
  localparam int COL_CNT_W     = 7;
  localparam int COL_CNT_RESET = 64;

  // shift control for the stack cell chain
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

endpackage

### hw/rtl/mrb_ram.sv
// mrb_ram: generic single write port, single read port ram with registered read
// no dependencies
module mrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/mrb_stack_cell.sv
// mrb_stack_cell: one entry of the shifting index stack
// depends on mrb_pkg for the shift control struct
module mrb_stack_cell #(
  parameter int EW = 13
) (
  input  logic              clk,
  input  mrb_pkg::stk_ctrl_t ctrl,
  input  logic [EW-1:0]     from_up,
  input  logic [EW-1:0]     from_down,
  output logic [EW-1:0]     q
);

  // push moves entries away from the top, pop moves them toward it
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      q <= from_up;
    end else if (ctrl.pop) begin
      q <= from_down;
    end
  end

endmodule

### hw/rtl/max_rectangle_binary_matrix.sv
// max_rectangle_binary_matrix: largest all-ones rectangle of a streamed binary matrix
// depends on mrb_pkg, mrb_ram (column heights) and mrb_stack_cell (stack chain)
// a cell inside a row passes ST_UPD, which writes its height, and returns to ST_IDLE;
//   a row-end cell then scans the row: ST_HREAD reads a height and ST_HSTEP pops the
//   stack chain while its top is not lower, then pushes the bar; after the last column
//   the pops drain the stack, then ST_HDONE and ST_FIN; start is taken only while idle
// reset (rst, synchronous): heights read as zero, best area zero, width register 64
module max_rectangle_binary_matrix #(
  parameter int MAX_COLS = mrb_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = mrb_pkg::MAX_ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [mrb_pkg::COL_CNT_W-1:0] cfg_wr_data,
  input  logic                         start,
  input  logic                         cell_req,
  input  logic                         last_in_matrix,
  output logic                         busy,
  output logic                         done,
  output logic [mrb_pkg::AREA_W-1:0]   max_area
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int NW = $clog2(MAX_COLS + 1);
  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int PW = HW + NW;
  localparam int EW = CW + HW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_UPD   = 3'd1;
  localparam logic [2:0] ST_HREAD = 3'd2;
  localparam logic [2:0] ST_HSTEP = 3'd3;
  localparam logic [2:0] ST_HDONE = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]                      state;
  logic [mrb_pkg::COL_CNT_W-1:0]   column_count;
  logic [CW-1:0]                   column_counter;
  logic [CW-1:0]                   col_r;
  logic                            cell_r;
  logic                            last_r;
  logic [NW-1:0]                   n_r;
  logic [NW-1:0]                   i_r;
  logic [MAX_COLS-1:0]             valid;
  logic [NW-1:0]                   sp;
  logic [PW-1:0]                   prod;
  logic                            prod_vld;
  logic [mrb_pkg::AREA_W-1:0]      best;

  logic [NW-1:0]                   width;
  logic [CW-1:0]                   col_calc;
  logic                            accept;
  logic [HW-1:0]                   rdata;
  logic [CW-1:0]                   raddr;
  logic                            ram_we;
  logic [HW-1:0]                   h_old;
  logic [HW-1:0]                   h_new;
  logic                            row_end;
  logic [HW-1:0]                   h_cur;
  logic [EW-1:0]                   cell_q [MAX_COLS];
  logic [EW-1:0]                   push_entry;
  logic [HW-1:0]                   top_h;
  logic [CW-1:0]                   nxt_idx;
  logic [NW-1:0]                   left;
  logic                            do_pop;
  mrb_pkg::stk_ctrl_t              stk_ctrl;
  logic [mrb_pkg::AREA_W-1:0]      area_sat;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // active row width, clamped to 1..MAX_COLS
  always_comb begin
    if (column_count == '0) begin
      width = NW'(1);
    end else if (int'(column_count) > MAX_COLS) begin
      width = NW'(MAX_COLS);
    end else begin
      width = NW'(column_count);
    end
  end

  assign col_calc = (NW'(column_counter) >= width) ? '0 : column_counter;

  // height update for the incoming cell
  assign h_old   = valid[col_r] ? rdata : '0;
  assign h_new   = !cell_r ? '0 :
                   ((int'(h_old) < MAX_ROWS) ? h_old + HW'(1) : h_old);
  assign row_end = ((NW'(col_r) + NW'(1)) >= width) || last_r;
  assign ram_we  = (state == ST_UPD);
  assign raddr   = (state == ST_IDLE) ? col_calc : i_r[CW-1:0];

  mrb_ram #(.WIDTH(HW), .DEPTH(MAX_COLS)) u_heights (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_r),
    .wdata (h_new),
    .raddr (raddr),
    .rdata (rdata)
  );

  // histogram scan: current bar and stack top
  assign h_cur      = ((i_r < n_r) && valid[i_r[CW-1:0]]) ? rdata : '0;
  assign top_h      = cell_q[0][HW-1:0];
  assign nxt_idx    = cell_q[1][EW-1:HW];
  assign left       = (sp >= NW'(2)) ? NW'(nxt_idx) + NW'(1) : '0;
  assign do_pop     = (state == ST_HSTEP) && (sp != '0) && (top_h >= h_cur);
  assign push_entry = {i_r[CW-1:0], h_cur};

  always_comb begin
    stk_ctrl.pop  = do_pop;
    stk_ctrl.push = (state == ST_HSTEP) && !do_pop && (i_r < n_r);
  end

  // shifting stack chain, top entry in cell 0
  for (genvar k = 0; k < MAX_COLS; k++) begin : g_stack
    logic [EW-1:0] up_d;
    logic [EW-1:0] down_d;
    if (k == 0) begin : g_top
      assign up_d = push_entry;
    end else begin : g_mid
      assign up_d = cell_q[k-1];
    end
    if (k == MAX_COLS - 1) begin : g_bot
      assign down_d = '0;
    end else begin : g_inner
      assign down_d = cell_q[k+1];
    end
    mrb_stack_cell #(.EW(EW)) u_cell (
      .clk       (clk),
      .ctrl      (stk_ctrl),
      .from_up   (up_d),
      .from_down (down_d),
      .q         (cell_q[k])
    );
  end

  // saturate the candidate area
  assign area_sat = (int'(prod) > mrb_pkg::AREA_MAX) ?
                    mrb_pkg::AREA_W'(mrb_pkg::AREA_MAX) : mrb_pkg::AREA_W'(prod);

  // product of a popped bar, registered before the compare
  always_ff @(posedge clk) begin
    if (do_pop) begin
      prod <= PW'(top_h) * PW'(i_r - left);
    end
  end

  // width register
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= mrb_pkg::COL_CNT_W'(mrb_pkg::COL_CNT_RESET);
    end else if (cfg_wr_en) begin
      column_count <= cfg_wr_data;
    end
  end

  // transaction latch
  always_ff @(posedge clk) begin
    if (accept) begin
      col_r  <= col_calc;
      cell_r <= cell_req;
      last_r <= last_in_matrix;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      column_counter <= '0;
      valid          <= '0;
      sp             <= '0;
      prod_vld       <= 1'b0;
      best           <= '0;
      done           <= 1'b0;
      n_r            <= '0;
      i_r            <= '0;
    end else begin
      done     <= (state == ST_FIN) && last_r;
      prod_vld <= do_pop;
      if (prod_vld && (area_sat > best)) begin
        best <= area_sat;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          valid[col_r] <= 1'b1;
          if (row_end) begin
            n_r            <= NW'(col_r) + NW'(1);
            i_r            <= '0;
            column_counter <= '0;
            state          <= ST_HREAD;
          end else begin
            column_counter <= col_r + CW'(1);
            state          <= ST_IDLE;
          end
        end
        ST_HREAD: begin
          state <= ST_HSTEP;
        end
        ST_HSTEP: begin
          if (do_pop) begin
            sp <= sp - NW'(1);
          end else if (i_r < n_r) begin
            sp    <= sp + NW'(1);
            i_r   <= i_r + NW'(1);
            state <= ST_HREAD;
          end else begin
            state <= ST_HDONE;
          end
        end
        ST_HDONE: begin
          sp    <= '0;
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (last_r) begin
            max_area       <= best;
            best           <= '0;
            valid          <= '0;
            column_counter <= '0;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // the result is shown only once the block is idle again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // the stack never holds more than a row
  a_sp_bound: assert property (@(posedge clk) disable iff (rst) int'(sp) <= MAX_COLS)
    else $error("stack overflow");

  // a pop needs a non-empty stack and shrinks it by one
  a_pop_sp: assert property (@(posedge clk) disable iff (rst)
    do_pop |=> (sp == $past(sp) - NW'(1)))
    else $error("pop did not shrink stack");

  // the stack is empty whenever a new transaction may start
  a_sp_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (sp == '0))
    else $error("stack not empty at idle");

endmodule

### dv/max_rectangle_binary_matrix_tb.sv
// max_rectangle_binary_matrix_tb: self-checking bench for the maximal rectangle block
// depends on mrb_pkg and max_rectangle_binary_matrix; predicts each area and checks it
`timescale 1ns / 1ps

module max_rectangle_binary_matrix_tb;

  localparam int NCOLS = mrb_pkg::MAX_COLS_DEF;
  localparam int NROWS = mrb_pkg::MAX_ROWS_DEF;
  localparam longint CYCLE_LIMIT = 3000000;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_wr_en = 1'b0;
  logic [mrb_pkg::COL_CNT_W-1:0] cfg_wr_data = '0;
  logic                          start = 1'b0;
  logic                          cell_req = 1'b0;
  logic                          last_in_matrix = 1'b0;
  logic                          busy;
  logic                          done;
  logic [mrb_pkg::AREA_W-1:0]    max_area;

  max_rectangle_binary_matrix dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .start(start), .cell_req(cell_req), .last_in_matrix(last_in_matrix),
    .busy(busy), .done(done), .max_area(max_area)
  );

  // clock, period 2 ns
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [mrb_pkg::COL_CNT_W-1:0] width_reg;
  int unsigned                   heights [NCOLS];
  int unsigned                   col_pos;
  int unsigned                   best_so_far;
  logic [mrb_pkg::AREA_W-1:0]    area_queue [$];
  int                            errors = 0;
  int                            matrices = 0;
  int                            cells_sent = 0;
  longint                        cycles = 0;
  int                            burst_left = 0;

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > NCOLS) return NCOLS;
    return 32'(width_reg);
  endfunction

  // largest rectangle under heights[0..n-1], brute force over column spans
  function automatic int unsigned row_area(int unsigned n);
    int unsigned top;
    int unsigned low;
    int unsigned a;
    top = 0;
    for (int l = 0; l < n; l++) begin
      low = heights[l];
      for (int r = l; r < n; r++) begin
        if (heights[r] < low) low = heights[r];
        a = low * (r - l + 1);
        if (a > top) top = a;
      end
    end
    return top;
  endfunction

  function automatic void predict_cell(logic bit_val, logic last);
    int unsigned w;
    int unsigned c;
    int unsigned a;
    w = eff_width();
    c = col_pos;
    if (c >= w) c = 0;
    if (bit_val) begin
      if (heights[c] < NROWS) heights[c]++;
    end else begin
      heights[c] = 0;
    end
    if (c + 1 >= w || last) begin
      a = row_area(c + 1);
      if (a > mrb_pkg::AREA_MAX) a = mrb_pkg::AREA_MAX;
      if (a > best_so_far) best_so_far = a;
      col_pos = 0;
    end else begin
      col_pos = c + 1;
    end
    if (last) begin
      area_queue.push_back(best_so_far[mrb_pkg::AREA_W-1:0]);
      foreach (heights[i]) heights[i] = 0;
      col_pos = 0;
      best_so_far = 0;
      matrices++;
    end
  endfunction

  // result checker: done is a one-cycle strobe
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (area_queue.size() == 0) begin
        $error("unexpected max_area result: actual %0d", max_area);
        errors <= errors + 1;
      end else begin
        if (max_area !== area_queue[0]) begin
          $error("max_area mismatch: expected %0d, actual %0d", area_queue[0], max_area);
          errors <= errors + 1;
        end
        area_queue.pop_front();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // send one cell transaction, with bursty random gaps
  task automatic send_cell(logic bit_val, logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    burst_left--;
    start = 1'b1;
    cell_req = bit_val;
    last_in_matrix = last;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_cell(bit_val, last);
    cells_sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  // wait for every outstanding area, then let the block settle
  task automatic drain();
    while (area_queue.size() != 0) @(negedge clk);
    repeat (2 * (NCOLS + 1) * 2 + 20) @(negedge clk);
  endtask

  task automatic write_width(logic [mrb_pkg::COL_CNT_W-1:0] w);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    width_reg = w;
  endtask

  // rows x cols matrix, ones with probability pct percent
  task automatic send_matrix(int rows, int cols, int pct);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        send_cell($urandom_range(0, 99) < pct, (r == rows - 1) && (c == cols - 1));
  endtask

  task automatic test_directed();
    // all ones at reset width, a few rows
    send_matrix(2, 64, 100);
    // all zeros, narrow rows
    write_width(7'd4);
    send_matrix(3, 4, 0);
    // single column, zero width acts as one
    write_width(7'd0);
    send_matrix(5, 1, 100);
    // width above the limit acts as the limit
    write_width(7'd127);
    send_matrix(1, 64, 100);
    // final mark mid-row closes the row early
    write_width(7'd5);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b1);
    // single-cell matrices
    write_width(7'd1);
    send_cell(1'b1, 1'b1);
    send_cell(1'b0, 1'b1);
  endtask

  // heights saturate at the row limit
  task automatic test_saturation();
    write_width(7'd3);
    send_matrix(66, 3, 100);
  endtask

  // width changed mid-row
  task automatic test_width_change();
    write_width(7'd6);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    write_width(7'd2);
    send_matrix(3, 2, 80);
  endtask

  task automatic test_random();
    int w;
    while (cells_sent < 1250) begin
      if ($urandom_range(0, 3) == 0) begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
        write_width(w[mrb_pkg::COL_CNT_W-1:0]);
      end
      w = eff_width();
      if ($urandom_range(0, 9) == 0) begin
        // broken matrix: early final mark
        repeat ($urandom_range(0, 2 * w)) begin
          send_cell(1'($urandom_range(0, 1)), 1'b0);
        end
        send_cell(1'($urandom_range(0, 1)), 1'b1);
      end else begin
        send_matrix($urandom_range(1, 6), w, $urandom_range(30, 95));
      end
    end
  endtask

  initial begin
    width_reg = mrb_pkg::COL_CNT_RESET;
    foreach (heights[i]) heights[i] = 0;
    col_pos = 0;
    best_so_far = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    repeat (2 * (NCOLS + 1)) @(negedge clk);
    test_directed();
    test_saturation();
    test_width_change();
    test_random();
    drain();
    $display("covered %0d cells in %0d matrices, widths 0 to 127, height saturation",
             cells_sent, matrices);
    $display("and early final marks, with bursty gaps and full drains");
    if (errors == 0 && area_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/mrb_pkg.sv
hw/rtl/mrb_ram.sv
hw/rtl/mrb_stack_cell.sv
hw/rtl/max_rectangle_binary_matrix.sv
dv/max_rectangle_binary_matrix_tb.sv
